@@ hdl/fisheye_texcoord_mapper_unit_defines.svh @@
// Assertion macros used by the mapper's top-level RTL file.
// Each use expects clk and rst_n in the enclosing scope.
`ifndef FISHEYE_TEXCOORD_MAPPER_UNIT_DEFINES_SVH
`define FISHEYE_TEXCOORD_MAPPER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define FTTM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fisheye mapper check failed");
`define FTTM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fisheye mapper check failed");
`else
`define FTTM_ASSERT_IMP(lbl, ante, cons)
`define FTTM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ hdl/fttm_pkg.sv @@
`default_nettype none
package fttm_pkg;

  localparam int ANGLE_FRAC_BITS     = 6;
  localparam int COORD_FRAC_BITS_DEF = 16;

  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // One full turn in input units, and constants for reducing an angle into it.
  localparam int          ANG_PERIOD = 360 << ANGLE_FRAC_BITS;
  localparam int          ANG_W      = $clog2(ANG_PERIOD);
  localparam logic [31:0] ANG_MR     = 32'((64'd1 << 32) / ANG_PERIOD);
  localparam int          ANG_OFF    = 32768 % ANG_PERIOD;
  localparam int          TURN_K     = ANG_W + 1;
  localparam logic [63:0] TURN_R     = (64'd1 << (32 + TURN_K)) / ANG_PERIOD;

  localparam int HC_LAT    = 3;
  localparam int SIN_TERMS = 7;
  localparam int COS_TERMS = 8;
  localparam int FRONT_LAT = 7;
  localparam int SC_LAT    = FRONT_LAT + COS_TERMS * HC_LAT + 1;
  localparam int SQ_STEPS  = 31;

  function automatic int sin_div(input int k);
    sin_div = (2 * k) * (2 * k + 1);
  endfunction

  function automatic int cos_div(input int k);
    cos_div = (2 * k - 1) * (2 * k);
  endfunction

  // Data handed from one Horner cell to the next.
  typedef struct packed {
    logic [31:0]        x2;
    logic signed [31:0] term;
  } fttm_hs_t;

  // Data handed from one square root cell to the next.
  typedef struct packed {
    logic [31:0] rad;
    logic [32:0] rem;
    logic [30:0] root;
  } fttm_sq_t;

  typedef struct packed {
    logic [30:0] mag_x;
    logic        neg_x;
    logic [30:0] mag_y;
    logic        neg_y;
    logic        pole;
  } fttm_side_t;

endpackage
`default_nettype wire

@@ hdl/fttm_hcell.sv @@
`default_nettype none
// One Horner step: term_out = 1 - floor(floor(x2 * max(term, 0) / 2^30) / DIV).
module fttm_hcell import fttm_pkg::*; #(
  parameter int DIV = 6
) (
  input  wire logic     clk,
  input  wire fttm_hs_t hs_in,
  output fttm_hs_t      hs_out
);

  localparam logic [39:0] RECIP = 40'((64'd1 << 40) / DIV);
  localparam logic [19:0] RC_LO = RECIP[19:0];
  localparam logic [19:0] RC_HI = RECIP[39:20];
  localparam logic [8:0]  DIV9  = 9'(DIV);

  logic [30:0]        tpos;
  logic [61:0]        prod;
  logic [31:0]        p_a_r, p_b_r;
  logic [31:0]        x2_a_r, x2_b_r, x2_c_r;
  logic [51:0]        pm_hi_r, pm_lo_r;
  logic [71:0]        msum;
  logic [31:0]        est;
  logic [8:0]         lowp, rem9;
  logic [31:0]        quo;
  logic signed [31:0] term_nxt, term_r;

  always_comb begin
    tpos = hs_in.term[31] ? 31'd0 : hs_in.term[30:0];
    prod = 62'(hs_in.x2) * 62'(tpos);
  end

  // The quotient estimate from the reciprocal is low by at most one.
  always_comb begin
    msum     = {pm_hi_r, 20'd0} + {20'd0, pm_lo_r};
    est      = msum[71:40];
    lowp     = est[8:0] * DIV9;
    rem9     = p_b_r[8:0] - lowp;
    quo      = est + {31'd0, (rem9 >= DIV9)};
    term_nxt = $signed({1'b0, ONE_Q30}) - $signed(quo);
  end

  always_ff @(posedge clk) begin
    p_a_r   <= prod[61:30];
    x2_a_r  <= hs_in.x2;
    pm_hi_r <= 52'(p_a_r) * 52'(RC_HI);
    pm_lo_r <= 52'(p_a_r) * 52'(RC_LO);
    p_b_r   <= p_a_r;
    x2_b_r  <= x2_a_r;
    term_r  <= term_nxt;
    x2_c_r  <= x2_b_r;
  end

  assign hs_out = '{x2: x2_c_r, term: term_r};

endmodule
`default_nettype wire

@@ hdl/fttm_sqcell.sv @@
`default_nettype none
// One restoring square root step: takes two radicand bits, yields one root bit.
module fttm_sqcell import fttm_pkg::*; (
  input  wire logic     clk,
  input  wire fttm_sq_t sq_in,
  output fttm_sq_t      sq_out
);

  logic [34:0] cur, trial, diff;
  fttm_sq_t    sq_nxt, sq_r;

  always_comb begin
    cur        = {sq_in.rem, sq_in.rad[31:30]};
    trial      = {2'b00, sq_in.root, 2'b01};
    diff       = cur - trial;
    sq_nxt.rad = {sq_in.rad[29:0], 2'b00};
    if (cur >= trial) begin
      sq_nxt.rem  = diff[32:0];
      sq_nxt.root = {sq_in.root[29:0], 1'b1};
    end else begin
      sq_nxt.rem  = cur[32:0];
      sq_nxt.root = {sq_in.root[29:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    sq_r <= sq_nxt;
  end

  assign sq_out = sq_r;

endmodule
`default_nettype wire

@@ hdl/fttm_sincos.sv @@
`default_nettype none
// Sine and cosine in Q30 of a raw angle, registered at the output.
module fttm_sincos import fttm_pkg::*; (
  input  wire logic        clk,
  input  wire logic [15:0] raw,
  output logic signed [31:0] sin_q,
  output logic signed [31:0] cos_q
);

  typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_t;

  localparam logic [31:0]      ANG_P   = 32'(ANG_PERIOD);
  localparam logic [31:0]      ANG_O   = 32'(ANG_OFF);
  localparam logic [ANG_W:0]   ANG_PW  = (ANG_W + 1)'(ANG_PERIOD);
  localparam logic [19:0]      TR_HI   = TURN_R[51:32];
  localparam logic [31:0]      TR_LO   = TURN_R[31:0];
  localparam int               HI_W    = ANG_W + 20;
  localparam int               LO_W    = ANG_W + 32;
  localparam int               TS_W    = 32 + TURN_K;
  localparam int               SIN_DLY = SIN_TERMS * HC_LAT;
  localparam int               ALIGN   = (COS_TERMS - SIN_TERMS) * HC_LAT - 1;

  logic [15:0]       u1_r;
  logic [47:0]       prod1_r;
  logic [15:0]       qe;
  logic [31:0]       qp, r0, r1, a32;
  logic [ANG_W-1:0]  a2_r;
  logic [HI_W-1:0]   pt_hi_r;
  logic [LO_W-1:0]   pt_lo_r;
  logic [TS_W-1:0]   tsum;
  logic [31:0]       est_r, t_r, t_nxt;
  logic [ANG_W:0]    lowp, remt;
  logic [60:0]       phi_prod;
  logic [61:0]       x2_prod;
  logic [30:0]       phi6_r, phi7_r;
  logic [1:0]        q6_r, q7_r;
  logic [31:0]       x2_r;
  logic [30:0]       phd_r [0:SIN_DLY-1];
  logic [1:0]        qd_r  [0:SIN_DLY-1];
  logic [30:0]       stpos;
  logic [61:0]       sp_prod;
  logic [31:0]       spd_r [0:ALIGN];
  logic [1:0]        qa_r  [0:ALIGN];
  logic [30:0]       s0, c0;
  logic signed [31:0] ct, s0s, c0s, sin_nxt, cos_nxt, sin_r, cos_r;

  fttm_hs_t sin_hs [0:SIN_TERMS];
  fttm_hs_t cos_hs [0:COS_TERMS];

  // Reduction of the angle into one turn; each estimate is corrected once.
  always_comb begin
    qe  = prod1_r[47:32];
    qp  = 32'(qe) * ANG_P;
    r0  = {16'd0, u1_r} - qp;
    r1  = (r0 >= ANG_P) ? r0 - ANG_P : r0;
    a32 = (r1 >= ANG_O) ? r1 - ANG_O : r1 + ANG_P - ANG_O;
  end

  // Turn fraction: the low bits of a*2^32 are zero, so the remainder is
  // known from the low bits of est*P alone.
  always_comb begin
    tsum     = TS_W'({pt_hi_r, 32'd0}) + TS_W'(pt_lo_r);
    lowp     = est_r[ANG_W:0] * ANG_PW;
    remt     = '0 - lowp;
    t_nxt    = est_r + 32'(remt >= ANG_PW);
    phi_prod = 61'(t_r[29:0]) * 61'(HALF_PI_Q30);
    x2_prod  = 62'(phi6_r) * 62'(phi6_r);
  end

  always_ff @(posedge clk) begin
    u1_r    <= raw ^ 16'h8000;
    prod1_r <= 48'(raw ^ 16'h8000) * 48'(ANG_MR);
    a2_r    <= a32[ANG_W-1:0];
    pt_hi_r <= HI_W'(a2_r) * HI_W'(TR_HI);
    pt_lo_r <= LO_W'(a2_r) * LO_W'(TR_LO);
    est_r   <= tsum[TS_W-1 -: 32];
    t_r     <= t_nxt;
    phi6_r  <= phi_prod[60:30];
    q6_r    <= t_r[31:30];
    x2_r    <= x2_prod[61:30];
    phi7_r  <= phi6_r;
    q7_r    <= q6_r;
  end

  assign sin_hs[0] = '{x2: x2_r, term: $signed({1'b0, ONE_Q30})};
  assign cos_hs[0] = '{x2: x2_r, term: $signed({1'b0, ONE_Q30})};

  for (genvar i = 0; i < SIN_TERMS; i++) begin : g_sin
    fttm_hcell #(.DIV(sin_div(SIN_TERMS - i))) u_cell (
      .clk    (clk),
      .hs_in  (sin_hs[i]),
      .hs_out (sin_hs[i+1])
    );
  end

  for (genvar i = 0; i < COS_TERMS; i++) begin : g_cos
    fttm_hcell #(.DIV(cos_div(COS_TERMS - i))) u_cell (
      .clk    (clk),
      .hs_in  (cos_hs[i]),
      .hs_out (cos_hs[i+1])
    );
  end

  always_comb begin
    ct      = sin_hs[SIN_TERMS].term;
    stpos   = ct[31] ? 31'd0 : ct[30:0];
    sp_prod = 62'(phd_r[SIN_DLY-1]) * 62'(stpos);
  end

  always_ff @(posedge clk) begin
    phd_r[0] <= phi7_r;
    qd_r[0]  <= q7_r;
    for (int i = 1; i < SIN_DLY; i++) begin
      phd_r[i] <= phd_r[i-1];
      qd_r[i]  <= qd_r[i-1];
    end
    spd_r[0] <= sp_prod[61:30];
    qa_r[0]  <= qd_r[SIN_DLY-1];
    for (int i = 1; i <= ALIGN; i++) begin
      spd_r[i] <= spd_r[i-1];
      qa_r[i]  <= qa_r[i-1];
    end
  end

  // Clamp to [0, 1] and unfold the quadrant.
  always_comb begin
    s0  = (spd_r[ALIGN] > 32'(ONE_Q30)) ? ONE_Q30 : spd_r[ALIGN][30:0];
    c0  = cos_hs[COS_TERMS].term[31] ? 31'd0 :
          ((cos_hs[COS_TERMS].term > $signed({1'b0, ONE_Q30})) ? ONE_Q30 :
           cos_hs[COS_TERMS].term[30:0]);
    s0s = $signed({1'b0, s0});
    c0s = $signed({1'b0, c0});
    case (quad_t'(qa_r[ALIGN]))
      QUAD_I: begin
        sin_nxt = s0s;
        cos_nxt = c0s;
      end
      QUAD_II: begin
        sin_nxt = c0s;
        cos_nxt = -s0s;
      end
      QUAD_III: begin
        sin_nxt = -s0s;
        cos_nxt = -c0s;
      end
      QUAD_IV: begin
        sin_nxt = -c0s;
        cos_nxt = s0s;
      end
      default: begin
        sin_nxt = s0s;
        cos_nxt = c0s;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    sin_r <= sin_nxt;
    cos_r <= cos_nxt;
  end

  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule
`default_nettype wire

@@ hdl/fisheye_texcoord_mapper_unit.sv @@
// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+-------------------------------
// input    | in_longitude, in_latitude               | transfer when start && !busy
// result   | out_tex_x, out_tex_y                    | transfer on the out_valid cycle
//
// A new item may be started in every cycle; busy stays low.
// Each result follows its transfer through the 32-stage sine/cosine front end
// and Horner cell chains, one prepare stage, the 31 cells of the square root
// chain and two output stages.
// Reset (rst_n low, synchronous) clears the valid line only; data in flight is dropped.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
`include "fisheye_texcoord_mapper_unit_defines.svh"
module fisheye_texcoord_mapper_unit import fttm_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] in_longitude,
  input  wire logic [15:0] in_latitude,
  output logic             out_valid,
  output logic [COORD_FRAC_BITS-1:0] out_tex_x,
  output logic [COORD_FRAC_BITS-1:0] out_tex_y
);

  localparam int TOTAL_LAT = SC_LAT + 1 + SQ_STEPS + 2;
  localparam int CW        = COORD_FRAC_BITS;

  localparam logic [60:0]   CENTRE = 61'd1 << 59;
  localparam logic [60:0]   RND    = 61'd1 << (59 - CW);
  localparam logic [CW-1:0] MID    = CW'(1) << (CW - 1);
  localparam logic signed [31:0] ONE_S = $signed({1'b0, ONE_Q30});

  logic [TOTAL_LAT-1:0] v_r, v_nxt;

  logic signed [31:0] su_q, cu_q, sv_q, cv_q;
  logic [31:0]        asv, acu, asu;
  logic [30:0]        m;
  fttm_side_t         side_nxt;
  fttm_sq_t           sq_t1_r;
  fttm_side_t         side_r [0:SQ_STEPS];
  fttm_sq_t           sq_chain [0:SQ_STEPS];

  logic [61:0]        hx_prod, hy_prod;
  logic [60:0]        half_x_r, half_y_r;
  logic               neg_x2_r, neg_y2_r, pole2_r;
  logic [CW-1:0]      tex_x_nxt, tex_y_nxt, tex_x_r, tex_y_r;

  // Place one axis: 0.5 +/- half in Q60, rounded half up, saturated.
  function automatic logic [CW-1:0] place(input logic neg, input logic [60:0] half);
    logic [60:0] v;
    logic [60:0] vr;
    logic [CW:0] sh;
    v  = neg ? CENTRE - half : CENTRE + half;
    vr = v + RND;
    sh = vr[60 -: CW + 1];
    place = sh[CW] ? {CW{1'b1}} : sh[CW-1:0];
  endfunction

  assign busy  = 1'b0;
  assign v_nxt = {v_r[TOTAL_LAT-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Both angles go through identical sine/cosine pipelines in lockstep.
  fttm_sincos u_lon (
    .clk   (clk),
    .raw   (in_longitude),
    .sin_q (su_q),
    .cos_q (cu_q)
  );

  fttm_sincos u_lat (
    .clk   (clk),
    .raw   (in_latitude),
    .sin_q (sv_q),
    .cos_q (cv_q)
  );

  // The planar direction flips with the sign of cos(latitude); the y axis is
  // flipped as well, so its sign test is inverted. A zero cosine marks a pole.
  always_comb begin
    asv            = sv_q[31] ? 32'(-sv_q) : 32'(sv_q);
    acu            = cu_q[31] ? 32'(-cu_q) : 32'(cu_q);
    asu            = su_q[31] ? 32'(-su_q) : 32'(su_q);
    m              = ONE_Q30 - ((asv > 32'(ONE_Q30)) ? ONE_Q30 : asv[30:0]);
    side_nxt.mag_x = acu[30:0];
    side_nxt.neg_x = cu_q[31] ^ cv_q[31];
    side_nxt.mag_y = asu[30:0];
    side_nxt.neg_y = ~(su_q[31] ^ cv_q[31]);
    side_nxt.pole  = (cv_q == '0);
  end

  always_ff @(posedge clk) begin
    sq_t1_r   <= '{rad: {1'b0, m}, rem: '0, root: '0};
    side_r[0] <= side_nxt;
    for (int i = 1; i <= SQ_STEPS; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  // The radial factor sqrt(1 - |sin v|) in Q30, one root bit per cell.
  assign sq_chain[0] = sq_t1_r;

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    fttm_sqcell u_cell (
      .clk    (clk),
      .sq_in  (sq_chain[i]),
      .sq_out (sq_chain[i+1])
    );
  end

  always_comb begin
    hx_prod = 62'(side_r[SQ_STEPS].mag_x) * 62'(sq_chain[SQ_STEPS].root);
    hy_prod = 62'(side_r[SQ_STEPS].mag_y) * 62'(sq_chain[SQ_STEPS].root);
  end

  always_ff @(posedge clk) begin
    half_x_r <= hx_prod[61:1];
    half_y_r <= hy_prod[61:1];
    neg_x2_r <= side_r[SQ_STEPS].neg_x;
    neg_y2_r <= side_r[SQ_STEPS].neg_y;
    pole2_r  <= side_r[SQ_STEPS].pole;
  end

  always_comb begin
    if (pole2_r) begin
      tex_x_nxt = MID;
      tex_y_nxt = MID;
    end else begin
      tex_x_nxt = place(neg_x2_r, half_x_r);
      tex_y_nxt = place(neg_y2_r, half_y_r);
    end
  end

  always_ff @(posedge clk) begin
    tex_x_r <= tex_x_nxt;
    tex_y_r <= tex_y_nxt;
  end

  assign out_valid = v_r[TOTAL_LAT-1];
  assign out_tex_x = tex_x_r;
  assign out_tex_y = tex_y_r;

  // Every result traces back to a start a fixed latency earlier.
  `FTTM_ASSERT_IMP(a_latency, out_valid, $past(start, TOTAL_LAT))
  // The folded cosine of the latitude never leaves [-1, 1].
  `FTTM_ASSERT_IMP(a_cos_range, v_r[SC_LAT-1], (cv_q <= ONE_S) && (cv_q >= -ONE_S))
  // The root of a radicand at most 2^60 stays within one in Q30.
  `FTTM_ASSERT_IMP(a_root_range, v_r[SC_LAT+SQ_STEPS], sq_chain[SQ_STEPS].root <= ONE_Q30)
  // A pole always lands on the centre of the image.
  `FTTM_ASSERT_NXT(a_pole_mid, v_r[TOTAL_LAT-2] && pole2_r, (out_tex_x == MID) && (out_tex_y == MID))

endmodule
`default_nettype wire
